// File: hdl/bhpq_pkg.sv
// Shared command and status codes and the heap ordering function for the priority queue.
package bhpq_pkg;

  // Command codes carried in the low bits of the request data.
  localparam logic [2:0] CMD_INSERT  = 3'd0;
  localparam logic [2:0] CMD_EXTRACT = 3'd1;
  localparam logic [2:0] CMD_PEEK    = 3'd2;
  localparam logic [2:0] CMD_DELETE  = 3'd3;
  localparam logic [2:0] CMD_SEARCH  = 3'd4;

  // Status codes returned with every response.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Fixed field widths of the request and response.
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  typedef logic signed [KEY_W-1:0] key_t;

  // True when key a belongs nearer the root than key b.
  function automatic logic ahead(input key_t a, input key_t b, input logic max_mode);
    ahead = max_mode ? (a > b) : (a < b);
  endfunction

endpackage

// File: hdl/bhpq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: sequencer, shared comparator and key store.
//
// Channel  Direction  Signals                        Contents
// s_*      in         s_tvalid s_tready s_tdata      command and key request
// m_*      out        m_tvalid m_tready m_tdata      root key, status and count
// cfg_*    in         cfg_valid cfg_ready cfg_data   max_mode register write
//
// Insert climbs a level at a time; peek reads the root; extract sifts down a level at a time,
// or ends early with one key held. Delete and search scan slot by slot up to the match; delete
// then moves the last key up or down as extract. A max_mode write rebuilds the heap by sifting
// down each of the count/2 internal slots. All of these steps share the one read port and the
// one shared comparator.
// Reset clears the count and sets max-heap mode; the key store is not cleared. A new request
// is taken while an earlier response waits; a finished response holds until it can load.
module binary_heap_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  // Fields from bit 0: command[2:0], value[34:3], zero padding.
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [39:0]             s_tdata,
  // Fields from bit 0: result_value[31:0], status[33:32], count, zero padding.
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [(((34 + $clog2(CAPACITY + 1)) + 7) / 8) * 8 - 1:0] m_tdata,
  // Write data: max_mode.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_data
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned OUT_W = ((34 + CNT_W + 7) / 8) * 8;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_SCAN_RD  = 15'b000000000000010,
    S_SCAN_CMP = 15'b000000000000100,
    S_ROOT_RD  = 15'b000000000001000,
    S_ROOT_GET = 15'b000000000010000,
    S_LAST_RD  = 15'b000000000100000,
    S_LAST_GET = 15'b000000001000000,
    S_UP_RD    = 15'b000000010000000,
    S_UP_CMP   = 15'b000000100000000,
    S_DN_L     = 15'b000001000000000,
    S_DN_R     = 15'b000010000000000,
    S_DN_CMP   = 15'b000100000000000,
    S_HEAP_RD  = 15'b001000000000000,
    S_HEAP_GET = 15'b010000000000000,
    S_RESP     = 15'b100000000000000
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      elem_count;
  logic                  max_mode;
  logic [2:0]            cmd;
  bhpq_pkg::key_t        val;
  bhpq_pkg::key_t        cur_key;
  bhpq_pkg::key_t        best_key;
  logic [AW-1:0]         best_idx;
  logic [AW-1:0]         hole;
  logic [AW-1:0]         scan_idx;
  logic [CNT_W-1:0]      heap_idx;
  logic                  up_only;
  logic                  heap_mode;
  bhpq_pkg::key_t        res_key;
  logic [1:0]            res_status;
  logic [OUT_W-1:0]      out_word;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  bhpq_pkg::key_t        mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [31:0]           mem_rdata;
  bhpq_pkg::key_t        rd_key;

  bhpq_pkg::key_t        cmp_a;
  bhpq_pkg::key_t        cmp_b;
  logic                  cmp_ahead;

  logic [AW+1:0]         l_idx;
  logic [AW+1:0]         r_idx;
  logic [AW+1:0]         count_ext;
  logic [AW-1:0]         hole_m1;
  logic [AW-1:0]         par_idx;
  logic                  l_ok;
  logic                  r_ok;
  logic                  take_r;
  logic [AW-1:0]         fin_idx;
  bhpq_pkg::key_t        fin_key;
  logic                  full;
  logic                  scan_last;

  // Key store.
  bhpq_ram #(
    .WIDTH (bhpq_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_key = bhpq_pkg::key_t'(mem_rdata);

  // Heap index arithmetic around the current hole.
  assign l_idx     = {1'b0, hole, 1'b1};
  assign r_idx     = l_idx + (AW + 2)'(1);
  assign count_ext = (AW + 2)'(elem_count);
  assign l_ok      = l_idx < count_ext;
  assign r_ok      = r_idx < count_ext;
  assign hole_m1   = hole - AW'(1);
  assign par_idx   = hole_m1 >> 1;
  assign full      = elem_count == CNT_W'(CAPACITY);
  assign scan_last = (CNT_W'(scan_idx) + CNT_W'(1)) >= elem_count;

  // Shared key comparator; its operands follow the sequencer state.
  always_comb begin
    cmp_a = cur_key;
    cmp_b = rd_key;
    unique case (state)
      S_DN_R: begin
        cmp_a = rd_key;
        cmp_b = cur_key;
      end
      S_DN_CMP: begin
        cmp_a = rd_key;
        cmp_b = best_key;
      end
      default: begin
        cmp_a = cur_key;
        cmp_b = rd_key;
      end
    endcase
  end

  assign cmp_ahead = bhpq_pkg::ahead(cmp_a, cmp_b, max_mode);

  // Pick of the sift-down step once both children have been compared.
  assign take_r  = r_ok && cmp_ahead;
  assign fin_idx = take_r ? AW'(r_idx) : best_idx;
  assign fin_key = take_r ? rd_key : best_key;

  // Key store read and write control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = hole;
    mem_wdata = cur_key;
    mem_raddr = hole;
    unique case (state)
      S_SCAN_RD: begin
        mem_raddr = scan_idx;
      end
      S_ROOT_RD: begin
        mem_raddr = '0;
      end
      S_LAST_RD: begin
        mem_raddr = AW'(elem_count - CNT_W'(1));
      end
      S_UP_RD: begin
        mem_raddr = par_idx;
        mem_we    = (hole == '0) && up_only;
      end
      S_UP_CMP: begin
        if (cmp_ahead) begin
          mem_we    = 1'b1;
          mem_wdata = rd_key;
        end else begin
          mem_we = up_only;
        end
      end
      S_DN_L: begin
        mem_raddr = AW'(l_idx);
        mem_we    = !l_ok;
      end
      S_DN_R: begin
        mem_raddr = AW'(r_idx);
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (fin_idx != hole) begin
          mem_wdata = fin_key;
        end
      end
      S_HEAP_RD: begin
        mem_raddr = AW'(heap_idx - CNT_W'(1));
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign s_tready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = state == S_IDLE;
  assign m_tdata  = out_word;

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      elem_count <= '0;
      max_mode   <= 1'b1;
      heap_mode  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // A taken response clears the output unless a new one loads in the same cycle.
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            max_mode  <= cfg_data;
            heap_idx  <= elem_count >> 1;
            heap_mode <= 1'b1;
            state     <= S_HEAP_RD;
          end else if (s_tvalid) begin
            cmd        <= s_tdata[2:0];
            val        <= bhpq_pkg::key_t'(s_tdata[34:3]);
            res_key    <= '0;
            res_status <= bhpq_pkg::ST_OK;
            heap_mode  <= 1'b0;
            case (s_tdata[2:0]) inside
              bhpq_pkg::CMD_INSERT: begin
                if (full) begin
                  res_status <= bhpq_pkg::ST_FULL;
                  state      <= S_RESP;
                end else begin
                  hole       <= AW'(elem_count);
                  cur_key    <= bhpq_pkg::key_t'(s_tdata[34:3]);
                  elem_count <= elem_count + CNT_W'(1);
                  up_only    <= 1'b1;
                  state      <= S_UP_RD;
                end
              end
              bhpq_pkg::CMD_EXTRACT, bhpq_pkg::CMD_PEEK: begin
                if (elem_count == '0) begin
                  res_status <= bhpq_pkg::ST_EMPTY;
                  state      <= S_RESP;
                end else begin
                  state <= S_ROOT_RD;
                end
              end
              bhpq_pkg::CMD_DELETE, bhpq_pkg::CMD_SEARCH: begin
                if (elem_count == '0) begin
                  res_status <= bhpq_pkg::ST_NOTFOUND;
                  state      <= S_RESP;
                end else begin
                  scan_idx <= '0;
                  state    <= S_SCAN_RD;
                end
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end

        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end

        // Linear search for the first slot holding the requested key.
        S_SCAN_CMP: begin
          if (rd_key == val) begin
            if (cmd == bhpq_pkg::CMD_DELETE) begin
              hole  <= scan_idx;
              state <= S_LAST_RD;
            end else begin
              state <= S_RESP;
            end
          end else if (scan_last) begin
            res_status <= bhpq_pkg::ST_NOTFOUND;
            state      <= S_RESP;
          end else begin
            scan_idx <= scan_idx + AW'(1);
            state    <= S_SCAN_RD;
          end
        end

        S_ROOT_RD: begin
          state <= S_ROOT_GET;
        end

        S_ROOT_GET: begin
          res_key <= rd_key;
          if (cmd == bhpq_pkg::CMD_PEEK) begin
            state <= S_RESP;
          end else begin
            hole  <= '0;
            state <= S_LAST_RD;
          end
        end

        S_LAST_RD: begin
          state <= S_LAST_GET;
        end

        // The last key moves into the freed slot unless the freed slot was the last.
        S_LAST_GET: begin
          cur_key    <= rd_key;
          elem_count <= elem_count - CNT_W'(1);
          up_only    <= 1'b0;
          if (CNT_W'(hole) < (elem_count - CNT_W'(1))) begin
            state <= S_UP_RD;
          end else begin
            state <= S_RESP;
          end
        end

        // Sift up: the root ends the climb.
        S_UP_RD: begin
          if (hole == '0) begin
            if (up_only) begin
              state <= heap_mode ? S_HEAP_RD : S_RESP;
            end else begin
              state <= S_DN_L;
            end
          end else begin
            state <= S_UP_CMP;
          end
        end

        // A parent that loses moves down into the hole; once moved, no sift-down follows.
        S_UP_CMP: begin
          if (cmp_ahead) begin
            hole    <= par_idx;
            up_only <= 1'b1;
            state   <= S_UP_RD;
          end else if (up_only) begin
            state <= heap_mode ? S_HEAP_RD : S_RESP;
          end else begin
            state <= S_DN_L;
          end
        end

        // Sift down: a hole with no children takes the carried key.
        S_DN_L: begin
          if (!l_ok) begin
            state <= heap_mode ? S_HEAP_RD : S_RESP;
          end else begin
            state <= S_DN_R;
          end
        end

        S_DN_R: begin
          if (cmp_ahead) begin
            best_key <= rd_key;
            best_idx <= AW'(l_idx);
          end else begin
            best_key <= cur_key;
            best_idx <= hole;
          end
          state <= S_DN_CMP;
        end

        S_DN_CMP: begin
          if (fin_idx == hole) begin
            state <= heap_mode ? S_HEAP_RD : S_RESP;
          end else begin
            hole  <= fin_idx;
            state <= S_DN_L;
          end
        end

        // Bottom-up rebuild after a mode change, one internal slot at a time.
        S_HEAP_RD: begin
          if (heap_idx == '0) begin
            heap_mode <= 1'b0;
            state     <= S_IDLE;
          end else begin
            state <= S_HEAP_GET;
          end
        end

        S_HEAP_GET: begin
          cur_key  <= rd_key;
          hole     <= AW'(heap_idx - CNT_W'(1));
          heap_idx <= heap_idx - CNT_W'(1);
          state    <= S_DN_L;
        end

        // Response waits here until the output register is free.
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            out_word <= OUT_W'({elem_count, res_status, res_key});
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    elem_count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  // A full response is only given with the store at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] == bhpq_pkg::ST_FULL) |->
      (m_tdata[34 +: CNT_W] == CNT_W'(CAPACITY)))
    else $error("full status with spare room");

  // An empty response carries a zero key and a zero count.
  a_empty_resp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] == bhpq_pkg::ST_EMPTY) |->
      (m_tdata[31:0] == '0) && (m_tdata[34 +: CNT_W] == '0))
    else $error("empty status with key or count");

  // An accepted insert with room grows the count by one in the next cycle.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[2:0] == bhpq_pkg::CMD_INSERT) && !full |=>
      (elem_count == $past(elem_count) + CNT_W'(1)))
    else $error("insert did not grow the count");

endmodule
